// File: src/assert_macros.svh
// Assertion wrappers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// checked on every rising clock edge, reset or not
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

// File: src/wsd_pkg.sv
`timescale 1ns / 1ps
package wsd_pkg;
    localparam int NUM_WORKERS   = 8;
    localparam int QUEUE_DEPTH   = 512;
    localparam int HANDLE_BITS   = 9;

    localparam int WID_BITS      = $clog2(NUM_WORKERS);
    localparam int VIC_BITS      = WID_BITS + 1;
    localparam int SLOT_BITS     = $clog2(QUEUE_DEPTH);
    localparam int IDX_BITS      = SLOT_BITS + 1;
    localparam int ADDR_BITS     = WID_BITS + SLOT_BITS;
    localparam int STORE_DEPTH   = NUM_WORKERS * QUEUE_DEPTH;
    localparam int WC_BITS       = 4;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    localparam int PADDR_BITS    = 3;
    localparam int PDATA_BITS    = 32;
    localparam logic REG_ACTIVE_WORKERS = 1'b0;
    localparam logic [WC_BITS-1:0] WC_RESET = WC_BITS'(NUM_WORKERS);

    typedef enum logic {
        MODE_PUSH  = 1'b0,
        MODE_FETCH = 1'b1
    } t_wsd_mode;

    // one classified request on its way to the store
    typedef struct packed {
        logic                   wr;
        logic                   rd;
        logic [ADDR_BITS-1:0]   addr;
        logic [HANDLE_BITS-1:0] handle;
        logic                   found;
        logic                   stolen;
        logic                   ovf;
        logic                   bad;
    } t_wsd_op;
endpackage

// File: src/wsd_if.sv
`timescale 1ns / 1ps
interface wsd_req_if;
    import wsd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [WID_BITS-1:0]    worker;
    logic [WID_BITS-1:0]    victim_pick;
    logic [HANDLE_BITS-1:0] job_handle;

    modport source (output valid, mode, worker, victim_pick, job_handle, input ready);
    modport sink   (input valid, mode, worker, victim_pick, job_handle, output ready);
endinterface

interface wsd_rsp_if;
    import wsd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [HANDLE_BITS-1:0] result_job;
    logic                   found;
    logic                   was_stolen;
    logic                   overflow;
    logic                   bad_victim;

    modport source (output valid, result_job, found, was_stolen, overflow, bad_victim,
                    input ready);
    modport sink   (input valid, result_job, found, was_stolen, overflow, bad_victim,
                    output ready);
endinterface

// File: src/wsd_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wsd_pkg::WC_BITS-1:0] i_active_workers,
    wsd_req_if.sink                     i_req,
    input  logic                        i_full,
    output logic                        o_push,
    output wsd_pkg::t_wsd_op            o_op
);
    import wsd_pkg::*;

    logic [IDX_BITS-1:0]  r_bottom [NUM_WORKERS];
    logic [IDX_BITS-1:0]  r_top    [NUM_WORKERS];
    logic [IDX_BITS-1:0]  n_bottom [NUM_WORKERS];
    logic [IDX_BITS-1:0]  n_top    [NUM_WORKERS];

    logic                 acc;
    logic [WID_BITS-1:0]  me;
    logic [IDX_BITS-1:0]  occ_me;
    logic [IDX_BITS-1:0]  b_inc;
    logic [IDX_BITS-1:0]  b_dec;
    logic [IDX_BITS-1:0]  top_inc;
    logic [WC_BITS-1:0]   eff;
    logic [VIC_BITS-1:0]  vic;
    logic [WID_BITS-1:0]  v_id;
    logic [IDX_BITS-1:0]  occ_v;
    logic [IDX_BITS-1:0]  tv_inc;
    t_wsd_op              op;

    assign i_req.ready = !i_full;
    assign acc         = i_req.valid && !i_full;
    assign me          = i_req.worker;
    assign occ_me      = r_bottom[me] - r_top[me];
    assign b_inc       = r_bottom[me] + IDX_BITS'(1);
    assign b_dec       = r_bottom[me] - IDX_BITS'(1);
    assign top_inc     = r_top[me] + IDX_BITS'(1);

    // clamp the configured worker count into 1..NUM_WORKERS
    always_comb begin
        if (i_active_workers == '0) begin
            eff = WC_BITS'(1);
        end else if (i_active_workers > WC_BITS'(NUM_WORKERS)) begin
            eff = WC_BITS'(NUM_WORKERS);
        end else begin
            eff = i_active_workers;
        end
    end

    // victim skips the requester
    assign vic    = VIC_BITS'(i_req.victim_pick) + VIC_BITS'(i_req.victim_pick >= me);
    assign v_id   = vic[WID_BITS-1:0];
    assign occ_v  = r_bottom[v_id] - r_top[v_id];
    assign tv_inc = r_top[v_id] + IDX_BITS'(1);

    always_comb begin
        n_bottom  = r_bottom;
        n_top     = r_top;
        op        = '0;
        op.handle = i_req.job_handle;
        if (i_req.mode == MODE_PUSH) begin
            if (occ_me[IDX_BITS-1]) begin
                op.ovf = 1'b1;
            end else begin
                op.wr        = 1'b1;
                op.addr      = {me, r_bottom[me][SLOT_BITS-1:0]};
                n_bottom[me] = b_inc;
            end
        end else begin
            if (occ_me != '0) begin
                op.rd    = 1'b1;
                op.found = 1'b1;
                op.addr  = {me, b_dec[SLOT_BITS-1:0]};
                if (occ_me == IDX_BITS'(1)) begin
                    // last job: both ends meet past the old top
                    n_top[me]    = top_inc;
                    n_bottom[me] = top_inc;
                end else begin
                    n_bottom[me] = b_dec;
                end
            end else if (eff < WC_BITS'(2)) begin
                op.bad = 1'b1;
            end else if (WC_BITS'(vic) >= eff) begin
                op.bad = 1'b1;
            end else if (occ_v != '0) begin
                op.rd       = 1'b1;
                op.found    = 1'b1;
                op.stolen   = 1'b1;
                op.addr     = {v_id, r_top[v_id][SLOT_BITS-1:0]};
                n_top[v_id] = tv_inc;
            end
        end
    end

    assign o_push = acc;
    assign o_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_bottom[i] <= '0;
                r_top[i]    <= '0;
            end
        end else if (acc) begin
            r_bottom <= n_bottom;
            r_top    <= n_top;
        end
    end

    `ASSERT_RST(a_occ_bound, i_clk, i_rst_n, acc |-> (occ_me <= IDX_BITS'(QUEUE_DEPTH)))
    `ASSERT_RST(a_push_adv, i_clk, i_rst_n, (acc && op.wr) |=> (r_bottom[$past(me)] == $past(b_inc)))
    `ASSERT_RST(a_one_kind, i_clk, i_rst_n, acc |-> !(op.wr && op.rd))
endmodule

// File: src/wsd_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_wsd_op i_data,
    output logic             o_full,
    input  logic             i_pop,
    output wsd_pkg::t_wsd_op o_data,
    output logic             o_empty
);
    import wsd_pkg::*;

    t_wsd_op                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp;
    logic [FIFO_PTR_BITS-1:0] r_rp;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] cnt_inc;
    logic                     do_push;
    logic                     do_pop;

    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign cnt_inc = r_count + FIFO_CNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + FIFO_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + FIFO_PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= cnt_inc;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CNT_BITS'(1);
            end
        end
    end

    `ASSERT_RST(a_cnt_max, i_clk, i_rst_n, r_count <= FIFO_CNT_BITS'(FIFO_DEPTH))
    `ASSERT_RST(a_cnt_up, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_count == $past(cnt_inc)))
    `ASSERT_RST(a_ptr_gap, i_clk, i_rst_n, (r_wp - r_rp) == r_count[FIFO_PTR_BITS-1:0])
endmodule

// File: src/wsd_back.sv
`timescale 1ns / 1ps
module wsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  wsd_pkg::t_wsd_op i_op,
    output logic             o_pop,
    wsd_rsp_if.source        o_rsp
);
    import wsd_pkg::*;

    logic [HANDLE_BITS-1:0] r_store [STORE_DEPTH];
    logic [HANDLE_BITS-1:0] r_rd;
    logic                   r_ov;
    logic                   r_found;
    logic                   r_stolen;
    logic                   r_ovf;
    logic                   r_bad;
    logic                   pop;

    // take the next op whenever the output register is free or draining
    assign pop   = i_valid && (!r_ov || o_rsp.ready);
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_op.wr) begin
                r_store[i_op.addr] <= i_op.handle;
            end
            if (i_op.rd) begin
                r_rd <= r_store[i_op.addr];
            end
            r_found  <= i_op.found;
            r_stolen <= i_op.stolen;
            r_ovf    <= i_op.ovf;
            r_bad    <= i_op.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (pop) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.result_job = r_found ? r_rd : '0;
    assign o_rsp.found      = r_found;
    assign o_rsp.was_stolen = r_stolen;
    assign o_rsp.overflow   = r_ovf;
    assign o_rsp.bad_victim = r_bad;
endmodule

// File: src/work_stealing_deque_scheduler_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// i_req     in   valid/ready            mode, worker, victim_pick, job_handle
// o_rsp     out  valid/ready            result_job, found, was_stolen, overflow,
//                                       bad_victim
// apb       in   psel/penable/pready    paddr, pwdata, prdata (active_workers @ 0x0)
//
// One item accepted per cycle while the op queue has room; one result per item.
// Each item is registered in the op queue, then its store read lands in the output reg.
// Rate is set by the single store port: one write or one read per item.
// Sync active-low reset clears pointers and queues; the job store is not cleared.
// A stalled o_rsp holds its item; the front keeps taking items until the queue fills.
module work_stealing_deque_scheduler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wsd_req_if.sink                        i_req,
    wsd_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wsd_pkg::PADDR_BITS-1:0] paddr,
    input  logic [wsd_pkg::PDATA_BITS-1:0] pwdata,
    output logic [wsd_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready
);
    import wsd_pkg::*;

    logic [WC_BITS-1:0] r_active_workers;
    logic               reg_sel;
    t_wsd_op            push_op;
    t_wsd_op            head_op;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    // register file: active_workers only, word index is paddr[2]
    assign reg_sel = (paddr[2] == REG_ACTIVE_WORKERS);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_BITS'(r_active_workers) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_workers <= WC_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_active_workers <= pwdata[WC_BITS-1:0];
        end
    end

    // front: pointer bookkeeping and classification
    wsd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_active_workers (r_active_workers),
        .i_req            (i_req),
        .i_full           (full),
        .o_push           (push),
        .o_op             (push_op)
    );

    // short decoupling queue
    wsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_op),
        .o_empty (empty)
    );

    // back: job store access and result register
    wsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!empty),
        .i_op    (head_op),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );
endmodule

// File: sim/work_stealing_deque_scheduler_top_test.sv
`timescale 1ns / 1ps
module work_stealing_deque_scheduler_top_test;
    import wsd_pkg::*;

    // idle cycles with no handshake on either channel before the run is called hung
    localparam int STALL_LIMIT  = 4000;
    // cycles allowed after the last result for a stray item to show up
    localparam int DRAIN_CYCLES = 10;
    // cap on printed mismatches so a broken block cannot flood the log
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        t_wsd_mode              mode;
        logic [WID_BITS-1:0]    worker;
        logic [WID_BITS-1:0]    victim_pick;
        logic [HANDLE_BITS-1:0] job_handle;
    } t_sched_req;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] result_job;
        logic                   found;
        logic                   was_stolen;
        logic                   overflow;
        logic                   bad_victim;
    } t_sched_rsp;

    // Mirror of the deques plus the queue of results still owed by the block.
    class deque_scoreboard;
        logic [HANDLE_BITS-1:0] jobs [NUM_WORKERS][QUEUE_DEPTH];
        logic [IDX_BITS-1:0]    bot_idx [NUM_WORKERS];
        logic [IDX_BITS-1:0]    top_idx [NUM_WORKERS];
        logic [WC_BITS-1:0]     workers_cfg;
        t_sched_rsp             owed_rsp [$];
        int unsigned            errors;

        function new();
            foreach (bot_idx[w]) begin
                bot_idx[w] = '0;
                top_idx[w] = '0;
            end
            workers_cfg = WC_RESET;
            errors      = 0;
        endfunction

        function void set_workers(logic [WC_BITS-1:0] value);
            workers_cfg = value;
        endfunction

        // indices run modulo 2*QUEUE_DEPTH, so the 10-bit difference is the fill level
        function logic [IDX_BITS-1:0] depth(int unsigned w);
            return bot_idx[w] - top_idx[w];
        endfunction

        function int unsigned outstanding();
            return owed_rsp.size();
        endfunction

        // Applies one request to the mirrored deques and returns the result it earns.
        function t_sched_rsp schedule(t_sched_req r);
            t_sched_rsp          o;
            logic [IDX_BITS-1:0] n;
            logic [IDX_BITS-1:0] nb;
            logic [IDX_BITS-1:0] nt;
            int unsigned         me;
            int unsigned         v;
            int unsigned         eff;
            o   = '0;
            me  = r.worker;
            eff = (workers_cfg == 0) ? 1 :
                  (workers_cfg > NUM_WORKERS) ? NUM_WORKERS : int'(workers_cfg);
            n   = depth(me);
            if (r.mode == MODE_PUSH) begin
                if (n >= QUEUE_DEPTH) begin
                    o.overflow = 1'b1;
                end else begin
                    jobs[me][bot_idx[me][SLOT_BITS-1:0]] = r.job_handle;
                    bot_idx[me] = bot_idx[me] + 1'b1;
                end
            end else if (n != 0) begin
                nb           = bot_idx[me] - 1'b1;
                o.result_job = jobs[me][nb[SLOT_BITS-1:0]];
                o.found      = 1'b1;
                if (n == 1) begin
                    // last job: both ends collapse onto old top + 1
                    nt          = top_idx[me] + 1'b1;
                    top_idx[me] = nt;
                    bot_idx[me] = nt;
                end else begin
                    bot_idx[me] = nb;
                end
            end else if (eff < 2) begin
                o.bad_victim = 1'b1;
            end else begin
                v = r.victim_pick + ((r.victim_pick >= r.worker) ? 1 : 0);
                if (v >= eff) begin
                    o.bad_victim = 1'b1;
                end else if (depth(v) != 0) begin
                    o.result_job = jobs[v][top_idx[v][SLOT_BITS-1:0]];
                    top_idx[v]   = top_idx[v] + 1'b1;
                    o.found      = 1'b1;
                    o.was_stolen = 1'b1;
                end
            end
            return o;
        endfunction

        function void note_request(t_sched_req r);
            owed_rsp.push_back(schedule(r));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_sched_rsp got);
            t_sched_rsp want;
            if (owed_rsp.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected item, expected none, actual %0h", $time, got);
                return;
            end
            want = owed_rsp.pop_front();
            compare_field("result_job", 32'(want.result_job), 32'(got.result_job));
            compare_field("found",      32'(want.found),      32'(got.found));
            compare_field("was_stolen", 32'(want.was_stolen), 32'(got.was_stolen));
            compare_field("overflow",   32'(want.overflow),   32'(got.overflow));
            compare_field("bad_victim", 32'(want.bad_victim), 32'(got.bad_victim));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    wsd_req_if req_ch ();
    wsd_rsp_if rsp_ch ();

    deque_scoreboard sb = new();

    // when set, the request side sends back to back with no gaps
    bit steady_send;

    work_stealing_deque_scheduler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none, otherwise a short gap, now and then a long hole.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request and notes it at the edge where it is taken.
    // valid stays high across back-to-back items, so there is only ever
    // one assignment to it per time step.
    task automatic issue(t_wsd_mode m, int unsigned w, int unsigned pick, int unsigned h);
        t_sched_req r;
        int         gap;
        r.mode        = m;
        r.worker      = WID_BITS'(w);
        r.victim_pick = WID_BITS'(pick);
        r.job_handle  = HANDLE_BITS'(h);
        gap = steady_send ? 0 : pause_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= r.mode;
        req_ch.worker      <= r.worker;
        req_ch.victim_pick <= r.victim_pick;
        req_ch.job_handle  <= r.job_handle;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(r);
    endtask

    // Lower valid and wait until every owed result is back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_active_workers(int unsigned value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(4 * REG_ACTIVE_WORKERS);
        pwdata  <= PDATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_workers(WC_BITS'(value));
    endtask

    // Empty every deque with own-queue pops so later steals have known sources.
    task automatic drain_all();
        for (int w = 0; w < NUM_WORKERS; w++)
            while (sb.depth(w) != 0)
                issue(MODE_FETCH, w, $urandom_range(0, 7), $urandom_range(0, 511));
    endtask

    // Fill one deque to the brim and bounce off it, take from both ends,
    // then push once more into the freed room.
    task automatic fill_one_queue();
        int unsigned owner;
        int unsigned thief;
        int unsigned thief_pick;
        owner      = $urandom_range(0, NUM_WORKERS - 1);
        thief      = (owner + 1 + $urandom_range(0, NUM_WORKERS - 2)) % NUM_WORKERS;
        // the pick is bumped past the thief itself, so undo that here
        thief_pick = (owner > thief) ? owner - 1 : owner;
        drain_all();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            issue(MODE_PUSH, owner, $urandom_range(0, 7), $urandom_range(0, 511));
        repeat (2) issue(MODE_FETCH, thief, thief_pick, $urandom_range(0, 511));
        repeat (2) issue(MODE_FETCH, owner, $urandom_range(0, 7), $urandom_range(0, 511));
        issue(MODE_PUSH, owner, $urandom_range(0, 7), $urandom_range(0, 511));
    endtask

    // Random pushes and fetches; victim pick mostly legal, sometimes the
    // out-of-range value 7.
    task automatic random_traffic(int count);
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0)
                steady_send = ($urandom_range(0, 3) == 0);
            pick = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, 6);
            issue(($urandom_range(0, 99) < 55) ? MODE_PUSH : MODE_FETCH,
                  $urandom_range(0, NUM_WORKERS - 1), pick, $urandom_range(0, 511));
        end
        steady_send = 1'b0;
    endtask

    // Response side: stretches with ready held high, others with random stalls.
    initial begin : rsp_backpressure
        int stall_left;
        int seg_left;
        bit steady;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        seg_left     = 0;
        steady       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 300);
                steady   = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (!steady && stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = pause_len();
            end
        end
    end

    // Values read right after the edge are the ones the block sampled there.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{result_job: rsp_ch.result_job, found: rsp_ch.found,
                              was_stolen: rsp_ch.was_stolen, overflow: rsp_ch.overflow,
                              bad_victim: rsp_ch.bad_victim});
    end

    // Hang detector: any handshake on either channel resets the count.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_PUSH;
        req_ch.worker      = '0;
        req_ch.victim_pick = '0;
        req_ch.job_handle  = '0;
        steady_send        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset setting of eight workers ----
        // nothing anywhere: own queue empty and victim 1 empty, plain miss
        issue(MODE_FETCH, 0, 0, 511);
        // handle extremes, two on worker 0
        issue(MODE_PUSH, 0, 0, 'h000);
        issue(MODE_PUSH, 0, 0, 'h1ff);
        issue(MODE_PUSH, 7, 0, 'h155);
        issue(MODE_PUSH, 3, 7, 'h0aa);
        // own pop is LIFO, then the last own job collapses the deque
        issue(MODE_FETCH, 0, 0, 0);
        issue(MODE_FETCH, 0, 0, 0);
        // pick 6 from worker 0 is bumped to victim 7: steal from the top
        issue(MODE_FETCH, 0, 6, 0);
        // pick 7 bumps to victim 8, past the last worker
        issue(MODE_FETCH, 1, 7, 0);
        // pick below the requester is not bumped: worker 5 steals from 3
        issue(MODE_FETCH, 5, 3, 'h1ff);

        // ---- single worker: no stealing at all ----
        write_active_workers(1);
        issue(MODE_FETCH, 4, 0, 0);
        // requester above the worker count still owns its queue
        issue(MODE_PUSH, 4, 3, 'h123);
        issue(MODE_FETCH, 4, 3, 0);

        // zero behaves like one
        write_active_workers(0);
        issue(MODE_FETCH, 2, 3, 0);

        // all ones clamps to the full worker set
        write_active_workers(15);
        issue(MODE_PUSH, 6, 0, 'h0f0);
        issue(MODE_FETCH, 0, 5, 0);

        // three workers: victim range cut at 3
        write_active_workers(3);
        issue(MODE_PUSH, 2, 0, 'h00f);
        issue(MODE_FETCH, 1, 2, 0);
        issue(MODE_FETCH, 1, 1, 0);
        issue(MODE_FETCH, 2, 0, 0);

        // ---- full queue and overflow on one worker ----
        write_active_workers(8);
        fill_one_queue();

        // ---- random traffic across several worker counts ----
        write_active_workers(2);
        random_traffic(10);
        write_active_workers(8);
        random_traffic(10);
        write_active_workers(1);
        random_traffic(5);
        write_active_workers(5);
        random_traffic(10);
        write_active_workers(15);
        random_traffic(5);
        write_active_workers(0);
        random_traffic(5);
        write_active_workers(7);
        random_traffic(10);

        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: work_stealing_deque_scheduler_top.f
+incdir+src
src/wsd_pkg.sv
src/wsd_if.sv
src/wsd_front.sv
src/wsd_fifo.sv
src/wsd_back.sv
src/work_stealing_deque_scheduler_top.sv
sim/work_stealing_deque_scheduler_top_test.sv
